FILE: sv/abp_pkg.sv
package abp_pkg;

  localparam int MAX_OBJECTS_DEF = 32;
  localparam int CRD_W           = 16;
  localparam int BND_W           = CRD_W + 1;
  localparam int ID_W            = 16;
  localparam int GRP_W           = 4;

  // world bounds and tag of the box under test, broadcast to every cell
  typedef struct packed {
    logic signed [BND_W-1:0] lx;
    logic signed [BND_W-1:0] ly;
    logic signed [BND_W-1:0] hx;
    logic signed [BND_W-1:0] hy;
    logic [ID_W-1:0]         id;
    logic [GRP_W-1:0]        grp;
  } probe_t;

  typedef struct packed {
    logic load_hit;  // latch the overlap flag of this cell
    logic shift;     // move flags and tags one cell towards the head
    logic wr;        // store the probe into the cell addressed by the count
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CMP   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

endpackage

FILE: sv/abp_cell.sv
module abp_cell import abp_pkg::*; #(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
  parameter int IDX         = 0,
  localparam int CNT_W      = $clog2(MAX_OBJECTS + 1)
) (
  input  logic             clk,
  input  probe_t           probe_i,
  input  cell_ctl_t        ctl_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic             nxt_hit_i,
  input  logic [ID_W-1:0]  nxt_id_i,
  input  logic [GRP_W-1:0] nxt_grp_i,
  output logic             hit_o,
  output logic [ID_W-1:0]  id_o,
  output logic [GRP_W-1:0] grp_o
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic signed [BND_W-1:0] lx_r, ly_r, hx_r, hy_r;
  logic [ID_W-1:0]         id_r;
  logic [GRP_W-1:0]        grp_r;
  logic                    sh_hit_r;
  logic [ID_W-1:0]         sh_id_r;
  logic [GRP_W-1:0]        sh_grp_r;
  logic                    occupied;
  logic                    overlap;

  assign occupied = IDX_C < count_i;
  // touching edges count as overlap
  assign overlap  = !(probe_i.lx > hx_r || probe_i.hx < lx_r ||
                      probe_i.ly > hy_r || probe_i.hy < ly_r);

  always_ff @(posedge clk) begin
    if (ctl_i.wr && count_i == IDX_C) begin
      lx_r  <= probe_i.lx;
      ly_r  <= probe_i.ly;
      hx_r  <= probe_i.hx;
      hy_r  <= probe_i.hy;
      id_r  <= probe_i.id;
      grp_r <= probe_i.grp;
    end
    if (ctl_i.load_hit) begin
      sh_hit_r <= occupied && (grp_r != probe_i.grp) && overlap;
      sh_id_r  <= id_r;
      sh_grp_r <= grp_r;
    end else if (ctl_i.shift) begin
      sh_hit_r <= nxt_hit_i;
      sh_id_r  <= nxt_id_i;
      sh_grp_r <= nxt_grp_i;
    end
  end

  assign hit_o = sh_hit_r;
  assign id_o  = sh_id_r;
  assign grp_o = sh_grp_r;

endmodule

FILE: sv/aabb_broad_phase_pairs_top.sv
// Broad-phase box pair finder.
// Input: one box per transfer, taken at a rising edge with start high and
// busy low. Shape offsets are added to the position to form world bounds.
// Output: one pair per cycle on the out_ ports, marked by out_strobe; the
// receiver cannot stall, so every result is shown for exactly one cycle.
// out_last marks the final result of an item; an item with no overlap
// gives no result at all. A box arriving with the store full gives a single
// result with out_dropped and out_last set.
// Sequence: with n boxes already stored, an item keeps busy high through
// a compare state, a scan state shifting the hit chain of the n boxes past
// the head cell, and a flush state; with n = 0 or a full store, through the
// compare state only. Each pair is held back until the next hit or the flush
// state so the final one can carry out_last, then leaves through an output
// register; a drop goes from the compare state straight to that register.
// All stored boxes are compared at once in the cell row; the hit flags then
// shift one cell per cycle towards the head, where the scan reads them out.
// Reset clears the store count and the control state; box contents are not
// cleared and never read beyond the count. frame_end empties the store
// after its item, including a dropped one.
module aabb_broad_phase_pairs_top import abp_pkg::*; #(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CRD_W-1:0] in_shape_min_x,
  input  logic signed [CRD_W-1:0] in_shape_min_y,
  input  logic signed [CRD_W-1:0] in_shape_max_x,
  input  logic signed [CRD_W-1:0] in_shape_max_y,
  input  logic signed [CRD_W-1:0] in_pos_x,
  input  logic signed [CRD_W-1:0] in_pos_y,
  input  logic [ID_W-1:0]         in_object_id,
  input  logic [GRP_W-1:0]        in_object_group,
  input  logic                    in_frame_end,
  output logic                    out_strobe,
  output logic [ID_W-1:0]         out_new_id,
  output logic [GRP_W-1:0]        out_new_group,
  output logic [ID_W-1:0]         out_other_id,
  output logic [GRP_W-1:0]        out_other_group,
  output logic                    out_dropped,
  output logic                    out_last
);

  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_OBJECTS);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_left_r, scan_left_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]  pend_id_r;
  logic [GRP_W-1:0] pend_grp_r;
  logic             fend_r;
  probe_t           probe_r;
  cell_ctl_t        ctl;
  logic             accept;

  logic             out_strobe_r, out_strobe_nxt;
  logic [ID_W-1:0]  out_other_id_r, out_other_id_nxt;
  logic [GRP_W-1:0] out_other_grp_r, out_other_grp_nxt;
  logic             out_dropped_r, out_dropped_nxt;
  logic             out_last_r, out_last_nxt;
  logic [ID_W-1:0]  out_new_id_r;
  logic [GRP_W-1:0] out_new_grp_r;

  logic             hit_chain [MAX_OBJECTS+1];
  logic [ID_W-1:0]  id_chain  [MAX_OBJECTS+1];
  logic [GRP_W-1:0] grp_chain [MAX_OBJECTS+1];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign hit_chain[MAX_OBJECTS] = 1'b0;
  assign id_chain[MAX_OBJECTS]  = '0;
  assign grp_chain[MAX_OBJECTS] = '0;

  for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
    abp_cell #(
      .MAX_OBJECTS (MAX_OBJECTS),
      .IDX         (i)
    ) u_cell (
      .clk       (clk),
      .probe_i   (probe_r),
      .ctl_i     (ctl),
      .count_i   (count_r),
      .nxt_hit_i (hit_chain[i+1]),
      .nxt_id_i  (id_chain[i+1]),
      .nxt_grp_i (grp_chain[i+1]),
      .hit_o     (hit_chain[i]),
      .id_o      (id_chain[i]),
      .grp_o     (grp_chain[i])
    );
  end

  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    scan_left_nxt     = scan_left_r;
    pend_v_nxt        = pend_v_r;
    ctl               = '0;
    out_strobe_nxt    = 1'b0;
    out_other_id_nxt  = pend_id_r;
    out_other_grp_nxt = pend_grp_r;
    out_dropped_nxt   = 1'b0;
    out_last_nxt      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (count_r == FULL) begin
          out_strobe_nxt    = 1'b1;
          out_other_id_nxt  = '0;
          out_other_grp_nxt = '0;
          out_dropped_nxt   = 1'b1;
          out_last_nxt      = 1'b1;
          count_nxt         = fend_r ? '0 : count_r;
          state_nxt         = ST_IDLE;
        end else begin
          ctl.load_hit  = 1'b1;
          ctl.wr        = 1'b1;
          scan_left_nxt = count_r;
          pend_v_nxt    = 1'b0;
          count_nxt     = fend_r ? '0 : count_r + ONE;
          state_nxt     = (count_r == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.shift = 1'b1;
        // hold one hit back so the final one can carry the last flag
        if (hit_chain[0]) begin
          out_strobe_nxt = pend_v_r;
          pend_v_nxt     = 1'b1;
        end
        scan_left_nxt = scan_left_r - ONE;
        if (scan_left_r == ONE) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        out_strobe_nxt = pend_v_r;
        out_last_nxt   = 1'b1;
        pend_v_nxt     = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      scan_left_r  <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      scan_left_r  <= scan_left_nxt;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      probe_r.lx  <= BND_W'(in_shape_min_x) + BND_W'(in_pos_x);
      probe_r.ly  <= BND_W'(in_shape_min_y) + BND_W'(in_pos_y);
      probe_r.hx  <= BND_W'(in_shape_max_x) + BND_W'(in_pos_x);
      probe_r.hy  <= BND_W'(in_shape_max_y) + BND_W'(in_pos_y);
      probe_r.id  <= in_object_id;
      probe_r.grp <= in_object_group;
      fend_r      <= in_frame_end;
    end
    if (state_r == ST_SCAN && hit_chain[0]) begin
      pend_id_r  <= id_chain[0];
      pend_grp_r <= grp_chain[0];
    end
    if (out_strobe_nxt) begin
      out_new_id_r    <= probe_r.id;
      out_new_grp_r   <= probe_r.grp;
      out_other_id_r  <= out_other_id_nxt;
      out_other_grp_r <= out_other_grp_nxt;
      out_dropped_r   <= out_dropped_nxt;
      out_last_r      <= out_last_nxt;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_new_id      = out_new_id_r;
  assign out_new_group   = out_new_grp_r;
  assign out_other_id    = out_other_id_r;
  assign out_other_group = out_other_grp_r;
  assign out_dropped     = out_dropped_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_dropped_r) |-> out_last_r)
    else $error("dropped result without last flag");

  a_drop_not_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_dropped_r) |=> !(out_strobe_r && out_dropped_r))
    else $error("dropped results in consecutive cycles");

  a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_left_r != '0))
    else $error("scan running with nothing left");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("store count beyond capacity");

  a_flush_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> $past(state_r == ST_SCAN))
    else $error("flush without preceding scan");
`endif

endmodule
